// ----- rtl/byte_diff_run_detector_top_macros.svh -----
// Assertion helpers used by the top block to check itself.
`ifndef BYTE_DIFF_RUN_DETECTOR_TOP_MACROS_SVH
`define BYTE_DIFF_RUN_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BDRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BDRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bdrd_pkg.sv -----
`default_nettype none

package bdrd_pkg;

	localparam int OUT_BITS       = 48;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GAP_LIMIT        = 2'd0,
		REG_STOP_AFTER_FIRST = 2'd1,
		REG_COMPARE_FIXED    = 2'd2,
		REG_FILL_BYTE        = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic       stop_after_first;
		logic       compare_fixed;
		logic [7:0] fill_byte;
	} cfg_flags_t;

	// What one accepted pair sends down the result pipeline.
	typedef struct packed {
		logic emit;    // a run closes on this pair
		logic at_end;  // it closes because the stream ended
		logic clr;     // the stream ends here: clear the running total after
	} tok_t;

endpackage

`default_nettype wire

// ----- rtl/bdrd_if.sv -----
`default_nettype none

interface bdrd_in_if;
	import bdrd_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] byte_a;
	logic [7:0] byte_b;
	logic       last_byte;

	modport source (output valid, output byte_a, output byte_b, output last_byte,
		input ready);
	modport sink (input valid, input byte_a, input byte_b, input last_byte,
		output ready);
endinterface

interface bdrd_out_if;
	import bdrd_pkg::*;
	logic                valid;
	logic                ready;
	logic [OUT_BITS-1:0] run_start;
	logic [OUT_BITS-1:0] run_length;
	logic [OUT_BITS-1:0] total_differing;
	logic                closed_at_end;

	modport source (output valid, output run_start, output run_length,
		output total_differing, output closed_at_end, input ready);
	modport sink (input valid, input run_start, input run_length,
		input total_differing, input closed_at_end, output ready);
endinterface

interface bdrd_cfg_if;
	import bdrd_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bdrd_track.sv -----
`default_nettype none

module bdrd_track #(
	parameter int POSITION_BITS = 48,
	parameter int GAP_BITS      = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     accept,
	input  wire logic [7:0]               byte_a,
	input  wire logic [7:0]               byte_b,
	input  wire logic                     last_byte,
	input  wire logic [GAP_BITS-1:0]      gap_limit,
	input  wire bdrd_pkg::cfg_flags_t     flags,
	output bdrd_pkg::tok_t                tok,
	output logic      [POSITION_BITS-1:0] tok_begin,
	output logic      [POSITION_BITS:0]   tok_span1,
	output logic      [GAP_BITS:0]        tok_eq
);
	import bdrd_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	logic                     open_q;
	logic [POSITION_BITS-1:0] begin_q;
	logic [GAP_BITS:0]        eq_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     stop_q;

	logic [7:0]               b_cmp;
	logic                     differ;
	logic [GAP_BITS:0]        eq_inc;
	logic                     close_gap;
	logic                     open_after;
	logic [POSITION_BITS-1:0] begin_n;
	logic [GAP_BITS:0]        eq_n;
	logic [POSITION_BITS-1:0] pos_inc;

	always_comb begin
		b_cmp      = flags.compare_fixed ? flags.fill_byte : byte_b;
		differ     = byte_a != b_cmp;
		eq_inc     = eq_q + 1'b1;
		close_gap  = !stop_q && !differ && open_q && (eq_inc > {1'b0, gap_limit});
		open_after = differ || open_q;
		begin_n    = (differ && !open_q) ? pos_q : begin_q;
		eq_n       = differ ? '0 : (open_q ? eq_inc : eq_q);
		pos_inc    = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;

		tok.emit   = !stop_q && (close_gap || (last_byte && open_after));
		tok.at_end = !close_gap;
		tok.clr    = last_byte;
		tok_begin  = begin_n;
		tok_eq     = eq_n;
		// bytes from run start through the current byte
		tok_span1  = {1'b0, pos_q} - {1'b0, begin_n} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			begin_q <= '0;
			eq_q    <= '0;
			pos_q   <= '0;
			stop_q  <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				open_q  <= 1'b0;
				begin_q <= '0;
				eq_q    <= '0;
				pos_q   <= '0;
				stop_q  <= 1'b0;
			end else if (!stop_q) begin
				pos_q   <= pos_inc;
				open_q  <= open_after && !close_gap;
				eq_q    <= close_gap ? '0 : eq_n;
				begin_q <= begin_n;
				stop_q  <= close_gap && flags.stop_after_first;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/byte_diff_run_detector_top.sv -----
// Channel  Role     Request                     Payload
// pairs    sink     one aligned byte pair       byte_a, byte_b, last_byte
// runs     source   one closed difference run   run_start, run_length,
//                                               total_differing, closed_at_end
// cfg      sink     one register write          index, data (always ready)
//
// One byte pair is taken every cycle unless pairs stall; run tracking updates
// at the pair's edge. A closed run moves from the span stage (s1) through the
// length stage (s2) and the running-total adder into the output register.
// Pipeline stages move independently, so pairs keep flowing while a result
// waits; pairs stall only when every stage ahead holds a pending request.
// Reset clears all tracking state, totals and valid flags; registers read 0.
`default_nettype none
`include "byte_diff_run_detector_top_macros.svh"

module byte_diff_run_detector_top #(
	parameter int POSITION_BITS = 48,
	parameter int GAP_BITS      = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bdrd_in_if.sink   pairs,
	bdrd_out_if.source runs,
	bdrd_cfg_if.sink  cfg
);
	import bdrd_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	// configuration
	logic [GAP_BITS-1:0] gap_q;
	cfg_flags_t          flags_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q   <= '0;
			flags_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_GAP_LIMIT:        gap_q                    <= GAP_BITS'(cfg.data);
				REG_STOP_AFTER_FIRST: flags_q.stop_after_first <= cfg.data[0];
				REG_COMPARE_FIXED:    flags_q.compare_fixed    <= cfg.data[0];
				REG_FILL_BYTE:        flags_q.fill_byte        <= cfg.data[7:0];
				default:              gap_q                    <= gap_q;
			endcase
		end
	end

	// run tracking
	tok_t                     tok;
	logic [POSITION_BITS-1:0] tok_begin;
	logic [POSITION_BITS:0]   tok_span1;
	logic [GAP_BITS:0]        tok_eq;
	logic                     accept;

	bdrd_track #(
		.POSITION_BITS(POSITION_BITS),
		.GAP_BITS     (GAP_BITS)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.byte_a   (pairs.byte_a),
		.byte_b   (pairs.byte_b),
		.last_byte(pairs.last_byte),
		.gap_limit(gap_q),
		.flags    (flags_q),
		.tok      (tok),
		.tok_begin(tok_begin),
		.tok_span1(tok_span1),
		.tok_eq   (tok_eq)
	);

	// pipeline
	logic                     v_s1;
	tok_t                     tok_s1;
	logic [POSITION_BITS-1:0] begin_s1;
	logic [POSITION_BITS:0]   span1_s1;
	logic [GAP_BITS:0]        eq_s1;

	logic                     v_s2;
	tok_t                     tok_s2;
	logic [POSITION_BITS-1:0] begin_s2;
	logic [POSITION_BITS-1:0] len_s2;

	logic                     out_v_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [POSITION_BITS-1:0] len_q;
	logic [POSITION_BITS-1:0] tot_q;
	logic                     end_q;
	logic [POSITION_BITS-1:0] total_q;

	logic                     out_free;
	logic                     rdy_s2;
	logic                     rdy_s1;
	logic                     drain;
	logic [POSITION_BITS:0]   eq_x;
	logic [POSITION_BITS:0]   len_d;
	logic [POSITION_BITS-1:0] len_n;
	logic [POSITION_BITS:0]   sum;
	logic [POSITION_BITS-1:0] sum_sat;

	always_comb begin
		out_free    = !out_v_q || runs.ready;
		rdy_s2      = !v_s2 || !tok_s2.emit || out_free;
		rdy_s1      = !v_s1 || rdy_s2;
		pairs.ready = rdy_s1;
		accept      = pairs.valid && rdy_s1;
		drain       = v_s2 && rdy_s2;

		// a saturated position can leave more equal bytes than span: length one
		eq_x  = (POSITION_BITS + 1)'(eq_s1);
		len_d = span1_s1 - eq_x;
		if (eq_x >= span1_s1) begin
			len_n = POSITION_BITS'(1);
		end else if (len_d[POSITION_BITS]) begin
			len_n = POS_MAX;
		end else begin
			len_n = len_d[POSITION_BITS-1:0];
		end

		sum     = {1'b0, total_q} + {1'b0, len_s2};
		sum_sat = sum[POSITION_BITS] ? POS_MAX : sum[POSITION_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
			total_q <= '0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= accept && (tok.emit || tok.clr);
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (out_free) begin
				out_v_q <= drain && tok_s2.emit;
			end
			if (drain) begin
				if (tok_s2.clr) begin
					total_q <= '0;
				end else if (tok_s2.emit) begin
					total_q <= sum_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && rdy_s1) begin
			tok_s1   <= tok;
			begin_s1 <= tok_begin;
			span1_s1 <= tok_span1;
			eq_s1    <= tok_eq;
		end
		if (rdy_s2 && v_s1) begin
			tok_s2   <= tok_s1;
			begin_s2 <= begin_s1;
			len_s2   <= len_n;
		end
		if (out_free && drain && tok_s2.emit) begin
			start_q <= begin_s2;
			len_q   <= len_s2;
			tot_q   <= sum_sat;
			end_q   <= tok_s2.at_end;
		end
	end

	assign runs.valid           = out_v_q;
	assign runs.run_start       = OUT_BITS'(start_q);
	assign runs.run_length      = OUT_BITS'(len_q);
	assign runs.total_differing = OUT_BITS'(tot_q);
	assign runs.closed_at_end   = end_q;

	`BDRD_ASSERT_NOW(a_len_nonzero, out_v_q, len_q != '0, "reported run has zero length")
	`BDRD_ASSERT_NOW(a_total_covers, out_v_q, tot_q >= len_q, "total below run length")
	`BDRD_ASSERT_NEXT(a_total_clear, drain && tok_s2.clr, total_q == '0, "total not cleared at end")

endmodule

`default_nettype wire

// ----- sim/byte_diff_run_detector_checker.sv -----
`timescale 1ns / 1ps

module byte_diff_run_detector_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	bdrd_in_if        pairs,
	bdrd_out_if       runs,
	bdrd_cfg_if       cfg,
	output int        errors,
	output int        pending,
	output int        pairs_seen,
	output int        runs_seen
);
	import bdrd_pkg::*;

	localparam int POS_BITS = 48;
	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	typedef struct packed {
		logic [OUT_BITS-1:0] start;
		logic [OUT_BITS-1:0] length;
		logic [OUT_BITS-1:0] total;
		logic                at_end;
	} run_report_t;

	run_report_t expected_runs[$];

	// register shadows
	logic [15:0] gap_limit;
	logic        stop_after_first;
	logic        compare_fixed;
	logic [7:0]  fill_byte;

	// stream tracking
	logic                run_open;
	logic [POS_BITS-1:0] run_begin;
	logic [POS_BITS-1:0] position;
	logic [POS_BITS-1:0] total_diff;
	logic [16:0]         equal_run;
	logic                stopped;

	function automatic logic [POS_BITS-1:0] sat_sum(logic [POS_BITS-1:0] x,
		logic [POS_BITS-1:0] y);
		logic [POS_BITS:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[POS_BITS] ? POS_MAX : s[POS_BITS-1:0];
	endfunction

	function automatic void clear_stream();
		run_open   = 1'b0;
		run_begin  = '0;
		equal_run  = '0;
		position   = '0;
		total_diff = '0;
		stopped    = 1'b0;
	endfunction

	// Close the open run at the current position.
	function automatic run_report_t close_run(logic at_end);
		run_report_t         r;
		logic [POS_BITS-1:0] span;
		logic [POS_BITS-1:0] len;
		span = position - run_begin;
		// a saturated position can leave the trailing equal bytes wider than the span
		if (equal_run > span)
			len = POS_BITS'(1);
		else
			len = sat_sum(span - POS_BITS'(equal_run), POS_BITS'(1));
		total_diff = sat_sum(total_diff, len);
		r.start  = run_begin[OUT_BITS-1:0];
		r.length = len[OUT_BITS-1:0];
		r.total  = total_diff[OUT_BITS-1:0];
		r.at_end = at_end;
		run_open  = 1'b0;
		equal_run = '0;
		return r;
	endfunction

	function automatic void track_pair(logic [7:0] a, logic [7:0] b_in, logic last);
		logic [7:0] b;
		b = compare_fixed ? fill_byte : b_in;
		if (stopped) begin
			if (last)
				clear_stream();
			return;
		end
		if (a != b) begin
			if (!run_open) begin
				run_open  = 1'b1;
				run_begin = position;
			end
			equal_run = '0;
		end else if (run_open) begin
			equal_run = equal_run + 1'b1;
			if (equal_run > {1'b0, gap_limit}) begin
				expected_runs.push_back(close_run(1'b0));
				if (stop_after_first)
					stopped = 1'b1;
			end
		end
		if (last) begin
			if (run_open)
				expected_runs.push_back(close_run(1'b1));
			clear_stream();
		end else begin
			position = sat_sum(position, POS_BITS'(1));
		end
	endfunction

	task automatic check_run();
		run_report_t want;
		run_report_t got;
		got.start  = runs.run_start;
		got.length = runs.run_length;
		got.total  = runs.total_differing;
		got.at_end = runs.closed_at_end;
		runs_seen++;
		if (expected_runs.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: run with none expected: start %0d length %0d %s",
					got.start, got.length,
					$sformatf("total %0d end %0b", got.total, got.at_end));
		end else begin
			want = expected_runs.pop_front();
			if (got.start !== want.start || got.length !== want.length ||
				got.total !== want.total || got.at_end !== want.at_end) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: run %0d expected start %0d length %0d total %0d end %0b",
						runs_seen, want.start, want.length, want.total, want.at_end);
					$display("       got      start %0d length %0d total %0d end %0b",
						got.start, got.length, got.total, got.at_end);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit        = '0;
			stop_after_first = 1'b0;
			compare_fixed    = 1'b0;
			fill_byte        = '0;
			clear_stream();
			expected_runs.delete();
			errors     = 0;
			pending    = 0;
			pairs_seen = 0;
			runs_seen  = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_GAP_LIMIT:        gap_limit = cfg.data[15:0];
					REG_STOP_AFTER_FIRST: stop_after_first = cfg.data[0];
					REG_COMPARE_FIXED:    compare_fixed = cfg.data[0];
					REG_FILL_BYTE:        fill_byte = cfg.data[7:0];
					default: ;
				endcase
			end
			if (pairs.valid && pairs.ready) begin
				track_pair(pairs.byte_a, pairs.byte_b, pairs.last_byte);
				pairs_seen++;
			end
			if (runs.valid && runs.ready)
				check_run();
			pending = expected_runs.size();
		end
	end

endmodule

// ----- sim/byte_diff_run_detector_top_tb.sv -----
`timescale 1ns / 1ps

module byte_diff_run_detector_top_tb;
	import bdrd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 180;
	localparam int HOLD_CYCLES  = 300;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bdrd_in_if  pairs ();
	bdrd_out_if runs ();
	bdrd_cfg_if cfg ();

	int errors;
	int pending;
	int pairs_seen;
	int runs_seen;
	int cycles         = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_len       = 0;

	logic hold_start;
	logic hold_taken = 1'b0;

	logic [15:0] cur_gap   = '0;
	logic        cur_fixed = 1'b0;
	logic [7:0]  cur_fill  = '0;

	always #5 clk = ~clk;

	byte_diff_run_detector_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pairs  (pairs),
		.runs   (runs),
		.cfg    (cfg)
	);

	byte_diff_run_detector_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pairs      (pairs),
		.runs       (runs),
		.cfg        (cfg),
		.errors     (errors),
		.pending    (pending),
		.pairs_seen (pairs_seen),
		.runs_seen  (runs_seen)
	);

	// Output side: hold ready low once when asked, else stall at random.
	always @(posedge clk) begin
		if (hold_start && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_len   <= HOLD_CYCLES - 1;
			runs.ready <= 1'b0;
		end else if (hold_len > 0) begin
			runs.ready <= 1'b0;
			hold_len   <= hold_len - 1;
		end else begin
			runs.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d runs still expected", cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_pair(logic [7:0] a, logic [7:0] b, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			pairs.valid <= 1'b0;
			@(posedge clk);
		end
		pairs.valid     <= 1'b1;
		pairs.byte_a    <= a;
		pairs.byte_b    <= b;
		pairs.last_byte <= last;
		do @(posedge clk); while (!pairs.ready);
	endtask

	// Send one pair that differs or matches under the current compare mode.
	task automatic send_kind(bit differ, bit last);
		logic [7:0] a;
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (cur_fixed)
			a = differ ? (cur_fill ^ 8'($urandom_range(255, 1))) : cur_fill;
		else
			a = differ ? (b ^ 8'($urandom_range(255, 1))) : b;
		send_pair(a, b, last);
	endtask

	// Alternate differing bursts and equal gaps, sized around gap_limit when it is at most 40.
	task automatic send_stream(int n);
		int  sent_cnt;
		int  seg;
		int  k;
		bit  differ;
		sent_cnt = 0;
		differ   = 1'($urandom_range(1));
		while (sent_cnt < n) begin
			if (differ)
				seg = $urandom_range(6, 1);
			else if (cur_gap > 40)
				seg = $urandom_range(12, 1);
			else begin
				case ($urandom_range(3))
					0: seg = int'(cur_gap);
					1: seg = cur_gap + 1;
					2: seg = $urandom_range(cur_gap);
					default: seg = $urandom_range(2 * cur_gap + 3);
				endcase
			end
			for (k = 0; k < seg && sent_cnt < n; k++) begin
				sent_cnt++;
				send_kind(differ, sent_cnt == n);
			end
			differ = !differ;
		end
	endtask

	task automatic send_noise(int n);
		int         k;
		logic [7:0] a;
		logic [7:0] b;
		for (k = 0; k < n; k++) begin
			a = 8'($urandom_range(255));
			b = ($urandom_range(3) == 0) ? a : 8'($urandom_range(255));
			send_pair(a, b, $urandom_range(7) == 0);
		end
	endtask

	// Stop sending and wait until every expected run has come out.
	task automatic wait_for_runs();
		pairs.valid <= 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [15:0] gap, logic stop, logic fixed, logic [7:0] fill);
		int                       i;
		cfg_reg_t                 idx;
		logic [CFG_DATA_BITS-1:0] d;
		for (i = 0; i < 4; i++) begin
			idx = cfg_reg_t'(i);
			case (idx)
				REG_GAP_LIMIT:        d = gap;
				REG_STOP_AFTER_FIRST: d = CFG_DATA_BITS'(stop);
				REG_COMPARE_FIXED:    d = CFG_DATA_BITS'(fixed);
				default:              d = CFG_DATA_BITS'(fill);
			endcase
			cfg.valid <= 1'b1;
			cfg.index <= idx;
			cfg.data  <= d;
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
		cur_gap   = gap;
		cur_fixed = fixed;
		cur_fill  = fill;
	endtask

	initial begin
		int ph;
		int sent;
		int len;
		int k;
		bit paused;

		hold_start      = 1'b0;
		pairs.valid     <= 1'b0;
		pairs.byte_a    <= '0;
		pairs.byte_b    <= '0;
		pairs.last_byte <= 1'b0;
		cfg.valid       <= 1'b0;
		cfg.index       <= REG_GAP_LIMIT;
		cfg.data        <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: gap 0, two streams compared
		send_pair(8'h00, 8'h00, 1'b0);
		send_pair(8'hFF, 8'h00, 1'b0);
		send_pair(8'hFF, 8'hFF, 1'b0);
		send_pair(8'h00, 8'hFF, 1'b0);
		send_pair(8'hAA, 8'h55, 1'b0);
		send_pair(8'h12, 8'h12, 1'b0);
		send_pair(8'h34, 8'h34, 1'b1);  // end with no run open
		send_pair(8'hFF, 8'h00, 1'b1);  // one-byte stream that differs
		send_pair(8'h01, 8'h02, 1'b0);
		send_pair(8'h80, 8'h7F, 1'b1);  // run closed by stream end
		send_pair(8'h01, 8'h02, 1'b0);
		send_pair(8'h05, 8'h05, 1'b1);  // gap close on the last byte
		send_pair(8'h00, 8'h00, 1'b1);
		wait_for_runs();

		set_config(16'd0, 1'b1, 1'b0, 8'h00);
		send_pair(8'h55, 8'hAA, 1'b0);
		send_pair(8'h00, 8'h00, 1'b0);  // closes first run, stop from here
		send_pair(8'hFF, 8'h00, 1'b0);
		send_pair(8'hFF, 8'h00, 1'b1);
		send_pair(8'hFF, 8'h00, 1'b1);  // new stream reports again
		wait_for_runs();

		set_config(16'd0, 1'b0, 1'b1, 8'hFF);
		send_pair(8'hFF, 8'h00, 1'b0);
		send_pair(8'h00, 8'hFF, 1'b0);
		send_pair(8'h7F, 8'hFF, 1'b0);
		send_pair(8'hFF, 8'h12, 1'b1);
		wait_for_runs();

		// Fill the pipeline while the output is held off.
		set_config(16'd0, 1'b0, 1'b0, 8'h00);
		hold_start = 1'b1;
		for (k = 0; k < 150; k++)
			send_kind(k % 2 == 0, k == 149);
		wait_for_runs();

		paused = 1'b0;
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_config(16'd0, 1'b0, 1'b0, 8'h00);
				1: set_config(16'd2, 1'b0, 1'b1, 8'hFF);
				2: set_config(16'hFFFF, 1'b0, 1'b0, 8'h00);
				3: set_config(16'd1, 1'b1, 1'b0, 8'h5A);
				4: set_config(16'($urandom_range(6, 3)), 1'b0, 1'b1, 8'($urandom_range(255)));
				5: set_config(16'($urandom_range(8)), 1'b1, 1'b1, 8'h00);
				6: set_config(16'hFFFF, 1'b1, 1'b1, 8'hA5);
				default: set_config(16'($urandom_range(12)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 8'($urandom_range(255)));
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (ph == 3 && !paused && sent >= PHASE_ITEMS / 2) begin
					wait_for_runs();
					paused = 1'b1;
				end
				if ($urandom_range(9) == 0) begin
					send_noise(8);
					sent += 8;
				end else begin
					len = ($urandom_range(7) == 0) ? $urandom_range(120, 60)
						: $urandom_range(30, 2);
					send_stream(len);
					sent += len;
				end
			end
			// end any stream that noise left open
			send_kind(1'($urandom_range(1)), 1'b1);
			wait_for_runs();
		end

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		wait_for_runs();

		$display("Checked %0d runs from %0d byte pairs under %0d register settings,",
			runs_seen, pairs_seen, PHASES + 4);
		$display("four pacing modes, a %0d-cycle output hold-off and a full drain pause.",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
